// ===== rtl/core/rldc_pkg.sv =====
// Shared types and constants for the region list diff counter.
// No dependencies.
package rldc_pkg;
   localparam int MaxRegions = 256;
   localparam int IdxW = $clog2(MaxRegions);
   localparam int CntW = $clog2(MaxRegions + 1);

   typedef enum logic [1:0] {
      MODE_LOAD = 2'd0, MODE_PROBE = 2'd1, MODE_FINISH = 2'd2, MODE_NONE = 2'd3
   } mode_type;

   typedef enum logic [2:0] {
      ST_IDLE, ST_PROBE_RD, ST_PROBE_CMP, ST_FIN_RD, ST_FIN_CHK, ST_CLEAR, ST_OUT
   } state_type;

   typedef struct packed {
      logic load;
      logic probe_start;
      logic probe_cmp;
      logic fin_start;
      logic fin_chk;
      logic clear_done;
   } cmd_type;

   typedef struct packed {
      logic table_full;
      logic scan_last;
      logic hit;
   } stat_type;
endpackage

// ===== rtl/core/rldc_if.sv =====
// Valid/ready channel interfaces for requests and responses.
// Depends on rldc_pkg.
interface rldc_req_if import rldc_pkg::*; ();
   logic        valid;
   logic        ready;
   logic [1:0]  mode;
   logic [63:0] region_start;
   logic [63:0] region_end;
   logic [63:0] region_hash;
   modport source (output valid, mode, region_start, region_end, region_hash, input ready);
   modport sink (input valid, mode, region_start, region_end, region_hash, output ready);
endinterface

interface rldc_rsp_if import rldc_pkg::*; ();
   logic        valid;
   logic        ready;
   logic [15:0] changed_count;
   logic [63:0] changed_bytes;
   logic [8:0]  fresh_count;
   logic [15:0] lost_count;
   logic        table_overflow;
   modport source (output valid, changed_count, changed_bytes, fresh_count,
                   lost_count, table_overflow, input ready);
   modport sink (input valid, changed_count, changed_bytes, fresh_count,
                 lost_count, table_overflow, output ready);
endinterface

// ===== rtl/core/rldc_datapath.sv =====
// Region table memory, match marks, scan index and saturating counters.
// Depends on rldc_pkg.
module rldc_datapath import rldc_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  cmd_type     cmd,
   output stat_type    stat,
   input  logic [63:0] in_start,
   input  logic [63:0] in_end,
   input  logic [63:0] in_hash,
   output logic [15:0] changed_count,
   output logic [63:0] changed_bytes,
   output logic [8:0]  fresh_count,
   output logic [15:0] lost_count,
   output logic        table_overflow
);
   logic [191:0]      mem [MaxRegions];
   logic [191:0]      rd_ff;
   logic [MaxRegions-1:0] mark_ff;
   logic              mark_rd_ff;
   logic [63:0]       s_ff, e_ff, h_ff;
   logic [IdxW-1:0]   idx_ff;
   logic [CntW-1:0]   loaded_ff;
   logic [15:0]       mod_ff, rem_ff;
   logic [63:0]       sum_ff;
   logic [8:0]        add_ff;
   logic              ovf_ff;
   logic [63:0]       len;
   logic [64:0]       sum_in;
   logic              last;

   assign len    = e_ff - s_ff;
   assign sum_in = {1'b0, sum_ff} + {1'b0, len};
   assign last   = ({1'b0, idx_ff} + 1'b1) >= (CntW)'(loaded_ff);

   always_comb begin
      stat.table_full = (loaded_ff == CntW'(MaxRegions));
      stat.scan_last  = last || (loaded_ff == '0);
      stat.hit        = (rd_ff[191:128] == s_ff) && (rd_ff[127:64] == e_ff);
   end

   always_ff @(posedge clock) begin
      if (cmd.load && !stat.table_full)
         mem[loaded_ff[IdxW-1:0]] <= {in_start, in_end, in_hash};
      rd_ff      <= mem[idx_ff];
      mark_rd_ff <= mark_ff[idx_ff];
      if (cmd.probe_start) begin
         s_ff <= in_start;
         e_ff <= in_end;
         h_ff <= in_hash;
      end
   end

   always_ff @(posedge clock) begin
      if (reset || cmd.clear_done) begin
         loaded_ff <= '0;
         mod_ff    <= '0;
         rem_ff    <= '0;
         sum_ff    <= '0;
         ovf_ff    <= 1'b0;
         idx_ff    <= '0;
         add_ff    <= '0;
      end else begin
         if (cmd.load) begin
            if (stat.table_full) ovf_ff <= 1'b1;
            else begin
               mark_ff[loaded_ff[IdxW-1:0]] <= 1'b0;
               loaded_ff <= loaded_ff + 1'b1;
            end
         end
         if (cmd.probe_start || cmd.fin_start) idx_ff <= '0;
         if (cmd.fin_start) add_ff <= '0;
         if (cmd.probe_cmp) begin
            if (stat.hit && loaded_ff != '0) begin
               mark_ff[idx_ff] <= 1'b1;
               if (rd_ff[63:0] != h_ff) begin
                  if (mod_ff != 16'hFFFF) mod_ff <= mod_ff + 1'b1;
                  sum_ff <= sum_in[64] ? '1 : sum_in[63:0];
               end
            end else if (stat.scan_last) begin
               if (rem_ff != 16'hFFFF) rem_ff <= rem_ff + 1'b1;
            end else idx_ff <= idx_ff + 1'b1;
         end
         if (cmd.fin_chk && loaded_ff != '0) begin
            if (!mark_rd_ff) add_ff <= add_ff + 1'b1;
            if (!stat.scan_last) idx_ff <= idx_ff + 1'b1;
         end
      end
   end

   assign changed_count  = mod_ff;
   assign changed_bytes  = sum_ff;
   assign fresh_count    = add_ff;
   assign lost_count     = rem_ff;
   assign table_overflow = ovf_ff;
endmodule

// ===== rtl/core/rldc_controller.sv =====
// Sequencer for load, probe scan, finish scan and clear.
// Depends on rldc_pkg.
module rldc_controller import rldc_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     req_valid,
   input  logic [1:0] req_mode,
   output logic     req_ready,
   output logic     rsp_valid,
   input  logic     rsp_ready,
   output logic     snap,
   output cmd_type  cmd,
   input  stat_type stat
);
   state_type state_ff, state_in;
   logic      rsp_ff, rsp_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         rsp_ff   <= 1'b0;
      end else begin
         state_ff <= state_in;
         rsp_ff   <= rsp_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      rsp_in    = rsp_ff && !rsp_ready;
      cmd       = '0;
      snap      = 1'b0;
      req_ready = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               case (mode_type'(req_mode))
                  MODE_LOAD:   cmd.load = 1'b1;
                  MODE_PROBE: begin
                     cmd.probe_start = 1'b1;
                     state_in = ST_PROBE_RD;
                  end
                  MODE_FINISH: begin
                     cmd.fin_start = 1'b1;
                     state_in = ST_FIN_RD;
                  end
                  default: ;
               endcase
            end
         end
         ST_PROBE_RD:  state_in = ST_PROBE_CMP;
         ST_PROBE_CMP: begin
            cmd.probe_cmp = 1'b1;
            state_in = (stat.hit || stat.scan_last) ? ST_IDLE : ST_PROBE_RD;
         end
         ST_FIN_RD:    state_in = ST_FIN_CHK;
         ST_FIN_CHK: begin
            cmd.fin_chk = 1'b1;
            state_in = stat.scan_last ? ST_OUT : ST_FIN_RD;
         end
         ST_OUT: begin
            if (!rsp_ff || rsp_ready) begin
               snap = 1'b1;
               rsp_in = 1'b1;
               state_in = ST_CLEAR;
            end
         end
         ST_CLEAR: begin
            cmd.clear_done = 1'b1;
            state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   assign rsp_valid = rsp_ff;
endmodule

// ===== rtl/core/region_list_diff_counter_unit.sv =====
// Top level of the region list diff counter.
// Depends on rldc_pkg, rldc_if, rldc_controller and rldc_datapath.
//
// Usage: a request with mode load stores a new region in a 256-entry table,
// or sets the overflow flag if the table is full. A probe request scans the
// table in load order, each entry by a registered memory read on the single
// read port of the table, then a compare, and stops at the first entry whose
// start and end match. A finish request scans the match marks the same way,
// registers one response, then clears the counters. Mode 3 is taken and
// ignored. Responses sit in an output register; the block waits before
// loading it if the previous response is still held, so a stalled receiver
// holds a finish request back, and no request is taken while it waits.
// Reset clears counters and flags; each load clears the mark of the entry
// it writes. The table contents stay undefined and are never used before
// written.
module region_list_diff_counter_unit import rldc_pkg::*; (
   input logic clock,
   input logic reset,
   rldc_req_if.sink   req,
   rldc_rsp_if.source rsp
);
   cmd_type  cmd;
   stat_type stat;
   logic     snap;
   logic [15:0] mr, rr;
   logic [63:0] mb;
   logic [8:0]  ar;
   logic        ov;

   rldc_controller u_ctrl (
      .clock, .reset,
      .req_valid (req.valid), .req_mode (req.mode), .req_ready (req.ready),
      .rsp_valid (rsp.valid), .rsp_ready (rsp.ready),
      .snap, .cmd, .stat
   );

   rldc_datapath u_dp (
      .clock, .reset, .cmd, .stat,
      .in_start (req.region_start), .in_end (req.region_end),
      .in_hash (req.region_hash),
      .changed_count (mr), .changed_bytes (mb), .fresh_count (ar),
      .lost_count (rr), .table_overflow (ov)
   );

   always_ff @(posedge clock) begin
      if (snap) begin
         rsp.changed_count  <= mr;
         rsp.changed_bytes  <= mb;
         rsp.fresh_count    <= ar;
         rsp.lost_count     <= rr;
         rsp.table_overflow <= ov;
      end
   end
endmodule

// ===== rtl/core/rldc_checker.sv =====
// Port-level checks for the region list diff counter, bound to the top level.
// Depends on rldc_pkg.
module rldc_checker import rldc_pkg::*; (
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_ready,
   input logic [1:0] req_mode,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [8:0] rsp_added
);
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("response dropped under stall");
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_mode == MODE_PROBE |=> !req_ready)
      else $error("probe not scanned");
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_mode == MODE_LOAD |=> !rsp_valid || $past(rsp_valid))
      else $error("load produced response");
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_added <= 9'(MaxRegions))
      else $error("added count out of range");
endmodule

bind region_list_diff_counter_unit rldc_checker u_chk (
   .clock, .reset,
   .req_valid (req.valid), .req_ready (req.ready), .req_mode (req.mode),
   .rsp_valid (rsp.valid), .rsp_ready (rsp.ready), .rsp_added (rsp.fresh_count)
);
